/* hdl/pfcba_pkg.sv */
// Shared types and constants for the PFC ingress buffer admission unit.
// No dependencies; every other file in hdl/ refers to this package.
`timescale 1ns / 1ps
`default_nettype none

package pfcba_pkg;

   localparam int PORTS_DEF  = 32;
   localparam int QUEUES_DEF = 8;

   localparam int BYTES_W = 26;
   localparam int PKT_W   = 14;
   localparam int PORT_W  = 5;
   localparam int QUEUE_W = 3;
   localparam int FIXED_W = 29;
   localparam int THR_W   = 32;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef logic [BYTES_W-1:0]       cnt_type;
   typedef logic [BYTES_W:0]         wide_type;
   typedef logic [PKT_W-1:0]         pkt_type;
   typedef logic [FIXED_W-1:0]       fixed_type;
   typedef logic signed [THR_W-1:0]  thr_type;

   typedef enum logic [2:0] {
      REG_PFC_ENABLE    = 3'd0,
      REG_BUFFER_BYTES  = 3'd1,
      REG_RESERVE_BYTES = 3'd2,
      REG_RESUME_GAP    = 3'd3,
      REG_HEADROOM      = 3'd4,
      REG_ALPHA_SHIFT   = 3'd5,
      REG_ACTIVE_PORTS  = 3'd6
   } reg_index_type;

   localparam logic        RST_PFC_ENABLE   = 1'b1;
   localparam logic [25:0] RST_BUFFER_BYTES = 26'(12 * 1024 * 1024);
   localparam logic [19:0] RST_RESERVE      = 20'(4 * 1024);
   localparam logic [19:0] RST_RESUME_GAP   = 20'(3 * 1024);
   localparam logic [21:0] RST_HEADROOM     = 22'd0;
   localparam logic [3:0]  RST_ALPHA        = 4'd0;
   localparam logic [5:0]  RST_ACTIVE_PORTS = 6'd0;

   typedef struct packed {
      logic        pfc_enable;
      logic [25:0] buffer_bytes;
      logic [19:0] reserve_bytes;
      logic [19:0] resume_gap;
      logic [21:0] headroom_per_port;
      logic [3:0]  alpha_shift;
      logic [5:0]  active_ports;
   } cfg_type;

   typedef struct packed {
      logic    pause_flag;
      cnt_type headroom_used;
      cnt_type queue_bytes;
   } entry_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL,
      ST_THR0,
      ST_UPD,
      ST_THR1,
      ST_FIN
   } state_type;

endpackage

`default_nettype wire

/* hdl/pfcba_csr.sv */
// Configuration register file with APB-style access.
// Depends on pfcba_pkg for register indexes, reset values and cfg_type.
`timescale 1ns / 1ps
`default_nettype none

module pfcba_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [pfcba_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [pfcba_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic      [pfcba_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                     csr_pready,
   output pfcba_pkg::cfg_type                       cfg
);

   pfcba_pkg::cfg_type       cfg_ff, cfg_in;
   pfcba_pkg::reg_index_type idx;
   logic                     wr;

   assign idx        = pfcba_pkg::reg_index_type'(csr_paddr[4:2]);
   assign wr         = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (idx)
            pfcba_pkg::REG_PFC_ENABLE:    cfg_in.pfc_enable        = csr_pwdata[0];
            pfcba_pkg::REG_BUFFER_BYTES:  cfg_in.buffer_bytes      = csr_pwdata[25:0];
            pfcba_pkg::REG_RESERVE_BYTES: cfg_in.reserve_bytes     = csr_pwdata[19:0];
            pfcba_pkg::REG_RESUME_GAP:    cfg_in.resume_gap        = csr_pwdata[19:0];
            pfcba_pkg::REG_HEADROOM:      cfg_in.headroom_per_port = csr_pwdata[21:0];
            pfcba_pkg::REG_ALPHA_SHIFT:   cfg_in.alpha_shift       = csr_pwdata[3:0];
            pfcba_pkg::REG_ACTIVE_PORTS:  cfg_in.active_ports      = csr_pwdata[5:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (idx)
         pfcba_pkg::REG_PFC_ENABLE:    csr_prdata = 32'(cfg_ff.pfc_enable);
         pfcba_pkg::REG_BUFFER_BYTES:  csr_prdata = 32'(cfg_ff.buffer_bytes);
         pfcba_pkg::REG_RESERVE_BYTES: csr_prdata = 32'(cfg_ff.reserve_bytes);
         pfcba_pkg::REG_RESUME_GAP:    csr_prdata = 32'(cfg_ff.resume_gap);
         pfcba_pkg::REG_HEADROOM:      csr_prdata = 32'(cfg_ff.headroom_per_port);
         pfcba_pkg::REG_ALPHA_SHIFT:   csr_prdata = 32'(cfg_ff.alpha_shift);
         pfcba_pkg::REG_ACTIVE_PORTS:  csr_prdata = 32'(cfg_ff.active_ports);
         default:                      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pfc_enable        <= pfcba_pkg::RST_PFC_ENABLE;
         cfg_ff.buffer_bytes      <= pfcba_pkg::RST_BUFFER_BYTES;
         cfg_ff.reserve_bytes     <= pfcba_pkg::RST_RESERVE;
         cfg_ff.resume_gap        <= pfcba_pkg::RST_RESUME_GAP;
         cfg_ff.headroom_per_port <= pfcba_pkg::RST_HEADROOM;
         cfg_ff.alpha_shift       <= pfcba_pkg::RST_ALPHA;
         cfg_ff.active_ports      <= pfcba_pkg::RST_ACTIVE_PORTS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/pfcba_entry_ram.sv */
// Per-queue state memory: one write port, one read port, registered read data.
// Depends on pfcba_pkg for entry_type.
`timescale 1ns / 1ps
`default_nettype none

module pfcba_entry_ram #(
   parameter  int DEPTH  = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 we,
   input  wire logic [ADDR_W-1:0]    waddr,
   input  pfcba_pkg::entry_type      wdata,
   input  wire logic                 re,
   input  wire logic [ADDR_W-1:0]    raddr,
   output pfcba_pkg::entry_type      rdata
);

   pfcba_pkg::entry_type mem [DEPTH];
   pfcba_pkg::entry_type rdata_ff;

   assign rdata = rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

/* hdl/pfcba_engine.sv */
// Admission sequencer: read-modify-write of one queue entry per transaction,
// thresholds, pause/resume decisions and the result register.
// Depends on pfcba_pkg; drives the ports of pfcba_entry_ram.
`timescale 1ns / 1ps
`default_nettype none

module pfcba_engine #(
   parameter  int PORTS   = pfcba_pkg::PORTS_DEF,
   parameter  int QUEUES  = pfcba_pkg::QUEUES_DEF,
   localparam int ENTRIES = PORTS * QUEUES,
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  pfcba_pkg::cfg_type                     cfg,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_op,
   input  wire logic [pfcba_pkg::PORT_W-1:0]      req_port,
   input  wire logic [pfcba_pkg::QUEUE_W-1:0]     req_queue,
   input  pfcba_pkg::pkt_type                     req_bytes,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_admitted,
   output logic                                   rsp_pause,
   output logic                                   rsp_resume,
   output pfcba_pkg::cnt_type                     rsp_shared,
   output logic                                   ram_we,
   output logic [IDX_W-1:0]                       ram_waddr,
   output pfcba_pkg::entry_type                   ram_wdata,
   output logic                                   ram_re,
   output logic [IDX_W-1:0]                       ram_raddr,
   input  pfcba_pkg::entry_type                   ram_rdata
);

   typedef pfcba_pkg::cnt_type   count_type;
   typedef pfcba_pkg::wide_type  wcount_type;
   typedef pfcba_pkg::pkt_type   len_type;
   typedef pfcba_pkg::fixed_type charge_type;
   typedef pfcba_pkg::thr_type   sthr_type;

   function automatic count_type sat(input wcount_type v);
      return v[pfcba_pkg::BYTES_W] ? '1 : v[pfcba_pkg::BYTES_W-1:0];
   endfunction

   // free shared space, floor-shifted by alpha
   function automatic sthr_type dyn_thresh(input count_type total, input charge_type fixed,
                                           input count_type used, input logic [3:0] sh);
      sthr_type base;
      base = sthr_type'(total) - sthr_type'(fixed) - sthr_type'(used);
      return base >>> sh;
   endfunction

   pfcba_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0]     clr_ff, clr_in;

   logic             op_ff, in_range_ff;
   logic [IDX_W-1:0] idx_ff;
   len_type          ps_ff;
   count_type        shared_ff;

   charge_type fixed_ff;
   wcount_type nb_ff, hsum_ff, excess_ff;
   logic       over_hdrm_ff, plain_over_ff, over_buf_ff;
   len_type    from_h_ff, rest_ff, from_s_ff, add_ff;
   count_type  sh_cur_ff;
   sthr_type   thr0_ff, thr1_ff;
   count_type  q_n_ff, h_n_ff, shq_ff;
   logic       adm_ff;

   count_type  q_n, h_n, s_n;
   logic       adm;
   sthr_type   base0;
   len_type    from_h;
   logic       pause_now, resume_now, fin_go;

   logic       rsp_valid_ff;
   logic       rsp_adm_ff, rsp_pause_ff, rsp_resume_ff;
   count_type  rsp_shared_ff;

   count_type  q, h;
   logic       p;
   count_type  res;

   assign q   = ram_rdata.queue_bytes;
   assign h   = ram_rdata.headroom_used;
   assign p   = ram_rdata.pause_flag;
   assign res = count_type'(cfg.reserve_bytes);

   assign fin_go = (state_ff == pfcba_pkg::ST_FIN) && (!rsp_valid_ff || rsp_ready);

   // sequencer
   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         pfcba_pkg::ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == IDX_W'(ENTRIES - 1)) begin
               state_in = pfcba_pkg::ST_IDLE;
            end
         end
         pfcba_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = pfcba_pkg::ST_MUL;
            end
         end
         pfcba_pkg::ST_MUL:  state_in = pfcba_pkg::ST_THR0;
         pfcba_pkg::ST_THR0: state_in = pfcba_pkg::ST_UPD;
         pfcba_pkg::ST_UPD:  state_in = pfcba_pkg::ST_THR1;
         pfcba_pkg::ST_THR1: state_in = pfcba_pkg::ST_FIN;
         pfcba_pkg::ST_FIN: begin
            if (fin_go) begin
               state_in = pfcba_pkg::ST_IDLE;
            end
         end
         default: state_in = pfcba_pkg::ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pfcba_pkg::ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   // memory port
   assign ram_re    = req_ready && req_valid;
   assign ram_raddr = IDX_W'(int'(req_port) * QUEUES + int'(req_queue));
   assign ram_we    = (state_ff == pfcba_pkg::ST_CLEAR) || (fin_go && in_range_ff);
   assign ram_waddr = (state_ff == pfcba_pkg::ST_CLEAR) ? clr_ff : idx_ff;

   always_comb begin
      ram_wdata = '0;
      if (state_ff != pfcba_pkg::ST_CLEAR) begin
         ram_wdata.queue_bytes   = q_n_ff;
         ram_wdata.headroom_used = h_n_ff;
         ram_wdata.pause_flag    = pause_now ? 1'b1 : (resume_now ? 1'b0 : p);
      end
   end

   // capture
   always_ff @(posedge clock) begin
      if (ram_re) begin
         op_ff       <= req_op;
         in_range_ff <= (int'(req_port) < PORTS) && (int'(req_queue) < QUEUES);
         idx_ff      <= ram_raddr;
         ps_ff       <= req_bytes;
      end
   end

   // entry data arrives
   assign from_h = (h < count_type'(ps_ff)) ? h[pfcba_pkg::PKT_W-1:0] : ps_ff;

   always_ff @(posedge clock) begin
      if (state_ff == pfcba_pkg::ST_MUL) begin
         fixed_ff      <= charge_type'(cfg.active_ports) * charge_type'(cfg.headroom_per_port)
                        + charge_type'(cfg.active_ports) * charge_type'(cfg.reserve_bytes);
         nb_ff         <= wcount_type'(q) + wcount_type'(ps_ff);
         hsum_ff       <= wcount_type'(h) + wcount_type'(ps_ff);
         over_hdrm_ff  <= (wcount_type'(h) + wcount_type'(ps_ff))
                          > wcount_type'(cfg.headroom_per_port);
         plain_over_ff <= (wcount_type'(shared_ff) + wcount_type'(ps_ff))
                          > wcount_type'(cfg.buffer_bytes);
         from_h_ff     <= from_h;
         rest_ff       <= ps_ff - from_h;
         sh_cur_ff     <= (q > res) ? q - res : '0;
      end
   end

   assign base0 = dyn_thresh(cfg.buffer_bytes, fixed_ff, shared_ff, 4'd0);

   always_ff @(posedge clock) begin
      if (state_ff == pfcba_pkg::ST_THR0) begin
         thr0_ff     <= base0 >>> cfg.alpha_shift;
         over_buf_ff <= base0 < sthr_type'(ps_ff);
         from_s_ff   <= (count_type'(rest_ff) < sh_cur_ff) ? rest_ff
                                                           : sh_cur_ff[pfcba_pkg::PKT_W-1:0];
         excess_ff   <= nb_ff - wcount_type'(cfg.reserve_bytes);
         add_ff      <= ((nb_ff - wcount_type'(cfg.reserve_bytes)) < wcount_type'(ps_ff))
                        ? nb_ff[pfcba_pkg::PKT_W-1:0] - len_type'(cfg.reserve_bytes) : ps_ff;
      end
   end

   // counter update
   always_comb begin
      q_n = q;
      h_n = h;
      s_n = shared_ff;
      adm = op_ff;
      if (in_range_ff) begin
         if (!op_ff) begin
            if (cfg.pfc_enable) begin
               adm = !(over_hdrm_ff && over_buf_ff);
               if (adm) begin
                  if (nb_ff <= wcount_type'(cfg.reserve_bytes)) begin
                     q_n = nb_ff[pfcba_pkg::BYTES_W-1:0];
                  end else if (sthr_type'(excess_ff) > thr0_ff) begin
                     h_n = sat(hsum_ff);
                  end else begin
                     q_n = sat(nb_ff);
                     s_n = sat(wcount_type'(shared_ff) + wcount_type'(add_ff));
                  end
               end
            end else begin
               adm = !plain_over_ff;
               if (adm) begin
                  q_n = sat(nb_ff);
                  s_n = sat(wcount_type'(shared_ff) + wcount_type'(ps_ff));
               end
            end
         end else begin
            if (cfg.pfc_enable) begin
               h_n = h - count_type'(from_h_ff);
               q_n = (q > count_type'(rest_ff)) ? q - count_type'(rest_ff) : '0;
               s_n = (shared_ff > count_type'(from_s_ff))
                     ? shared_ff - count_type'(from_s_ff) : '0;
            end else begin
               q_n = (q > count_type'(ps_ff)) ? q - count_type'(ps_ff) : '0;
               s_n = (shared_ff > count_type'(ps_ff)) ? shared_ff - count_type'(ps_ff) : '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == pfcba_pkg::ST_UPD) begin
         q_n_ff <= q_n;
         h_n_ff <= h_n;
         adm_ff <= adm;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shared_ff <= '0;
      end else if (state_ff == pfcba_pkg::ST_UPD) begin
         shared_ff <= s_n;
      end
   end

   // threshold after the update
   always_ff @(posedge clock) begin
      if (state_ff == pfcba_pkg::ST_THR1) begin
         thr1_ff <= dyn_thresh(cfg.buffer_bytes, fixed_ff, shared_ff, cfg.alpha_shift);
         shq_ff  <= (q_n_ff > res) ? q_n_ff - res : '0;
      end
   end

   assign pause_now  = in_range_ff && !op_ff && cfg.pfc_enable && adm_ff && !p
                       && ((h_n_ff != '0) || (sthr_type'(shq_ff) >= thr1_ff));
   assign resume_now = in_range_ff && op_ff && p && (h_n_ff == '0)
                       && ((shq_ff == '0)
                           || (sthr_type'(wcount_type'(shq_ff) + wcount_type'(cfg.resume_gap))
                               <= thr1_ff));

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fin_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_go) begin
         rsp_adm_ff    <= adm_ff;
         rsp_pause_ff  <= pause_now;
         rsp_resume_ff <= resume_now;
         rsp_shared_ff <= shared_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_admitted = rsp_adm_ff;
   assign rsp_pause    = rsp_pause_ff;
   assign rsp_resume   = rsp_resume_ff;
   assign rsp_shared   = rsp_shared_ff;

endmodule

`default_nettype wire

/* hdl/pfc_ingress_buffer_admission_unit.sv */
// Top level of the PFC ingress buffer admission unit.
// Instantiates pfcba_csr, pfcba_entry_ram and pfcba_engine; uses pfcba_pkg.
//
// Accounts packet arrivals and departures per (port, queue): reserve and
// shared byte counts, headroom use and pause state live in one single-port-
// write RAM of PORTS*QUEUES entries; the shared total is a register. Each
// transaction passes from acceptance through fixed-charge multiply on the
// RAM read data, pre-update threshold, counter update, post-update threshold
// and write-back into the result register; the next request is taken in the
// cycle after the write-back, so none is taken while one is in flight; the
// read-modify-write of the RAM entry is the reason. A result that is not
// yet taken holds the write-back until the result register frees.
// After reset a clearing pass zeroes all PORTS*QUEUES RAM entries; requests
// are held off during it, while register writes are taken as usual.
`timescale 1ns / 1ps
`default_nettype none

module pfc_ingress_buffer_admission_unit #(
   parameter int PORTS  = pfcba_pkg::PORTS_DEF,
   parameter int QUEUES = pfcba_pkg::QUEUES_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // [4:0] port_index, [7:5] queue_index, [21:8] packet_bytes, [23:22] zero
   input  wire logic [23:0]                       req_tdata,
   // [0] operation
   input  wire logic                              req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [0] admitted, [1] pause_now, [2] resume_now, [28:3] shared_total, [31:29] zero
   output logic [31:0]                            rsp_tdata,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [pfcba_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [pfcba_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [pfcba_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                   csr_pready
);

   localparam int ENTRIES = PORTS * QUEUES;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   pfcba_pkg::cfg_type   cfg;
   logic                 ram_we, ram_re;
   logic [IDX_W-1:0]     ram_waddr, ram_raddr;
   pfcba_pkg::entry_type ram_wdata, ram_rdata;
   logic                 rsp_admitted, rsp_pause, rsp_resume;
   pfcba_pkg::cnt_type   rsp_shared;

   pfcba_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pfcba_entry_ram #(
      .DEPTH (ENTRIES)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   pfcba_engine #(
      .PORTS  (PORTS),
      .QUEUES (QUEUES)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_op       (req_tuser),
      .req_port     (req_tdata[4:0]),
      .req_queue    (req_tdata[7:5]),
      .req_bytes    (req_tdata[21:8]),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_admitted (rsp_admitted),
      .rsp_pause    (rsp_pause),
      .rsp_resume   (rsp_resume),
      .rsp_shared   (rsp_shared),
      .ram_we       (ram_we),
      .ram_waddr    (ram_waddr),
      .ram_wdata    (ram_wdata),
      .ram_re       (ram_re),
      .ram_raddr    (ram_raddr),
      .ram_rdata    (ram_rdata)
   );

   assign rsp_tdata = {3'b000, rsp_shared, rsp_resume, rsp_pause, rsp_admitted};

endmodule

`default_nettype wire
